// File: rtl/core/mer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int COORD_BITS_DEF = 11;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_RX2,
    DST_RY2,
    DST_T,
    DST_U,
    DST_DX,
    DST_DY,
    DST_DEC
  } dst_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_RX2,
    ST_LD_RY2,
    ST_LD_T,
    ST_LD_DY,
    ST_LD_D0,
    ST_LD_D1,
    ST_CHK,
    ST_SW0,
    ST_SW1,
    ST_SW2,
    ST_SW3,
    ST_SW4,
    ST_SW5,
    ST_SW6,
    ST_SW7,
    ST_EMIT,
    ST_UP0,
    ST_UP1,
    ST_UP2,
    ST_UP3,
    ST_UP4
  } state_t;

endpackage

// File: rtl/core/midpoint_ellipse_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit
// Midpoint ellipse walker: one point group of four symmetric points per step.
// ----------------------------------------------------------------------------
// A start transfer loads radii and center before in_ready returns; it gives
// no result. A step transfer runs CHK, EMIT and UP0 to UP2 when the decision
// branch keeps the walk on one axis, adds UP3 and UP4 when both coordinates
// move, and adds SW0 to SW7 on the step that crosses from region 1 to region
// 2. A step while no ellipse is active gives nothing. All of it runs through
// a single shared add/subtract/multiply unit under a small sequencer; the
// result sits in an output register, so the walk continues while a point
// group waits, and only the next emit stalls on out_ready. Decision values
// are kept scaled by 4; coordinates wrap to COORD_BITS+1.
module midpoint_ellipse_rasterizer_unit
  import mer_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [COORD_BITS-2:0]        in_radius_x,
  input  logic [COORD_BITS-2:0]        in_radius_y,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   out_px_a,
  output logic signed [COORD_BITS:0]   out_py_a,
  output logic signed [COORD_BITS:0]   out_px_b,
  output logic signed [COORD_BITS:0]   out_py_b,
  output logic signed [COORD_BITS:0]   out_px_c,
  output logic signed [COORD_BITS:0]   out_py_c,
  output logic signed [COORD_BITS:0]   out_px_d,
  output logic signed [COORD_BITS:0]   out_py_d,
  output logic                         out_last
);

  localparam int RAD_BITS = COORD_BITS - 1;
  localparam int DEC_W    = 4 * RAD_BITS + 8;
  localparam int DX_W     = 3 * RAD_BITS + 3;
  localparam int MB_W     = RAD_BITS + 3;
  localparam int R2W      = 2 * RAD_BITS;
  localparam int XW       = RAD_BITS + 1;
  localparam int YW       = RAD_BITS + 2;
  localparam int OW       = COORD_BITS + 1;

  state_t state_r, state_nxt;

  logic                     active_r, active_nxt;
  logic                     r2_r, r2_nxt;
  logic                     br_r, br_nxt;
  logic [XW-1:0]            x_r, x_nxt;
  logic signed [YW-1:0]     y_r, y_nxt;
  logic signed [DX_W-1:0]   dx_r, dx_nxt;
  logic signed [DX_W-1:0]   dy_r, dy_nxt;
  logic signed [DEC_W-1:0]  dec_r, dec_nxt;
  logic signed [DEC_W-1:0]  t_r, t_nxt;
  logic signed [DEC_W-1:0]  u_r, u_nxt;
  logic [RAD_BITS-1:0]      rx_r, rx_nxt;
  logic [RAD_BITS-1:0]      ry_r, ry_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [R2W-1:0]           rx2_r, rx2_nxt;
  logic [R2W-1:0]           ry2_r, ry2_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [OW-1:0]     px_a_r, py_a_r, px_b_r, py_b_r;
  logic signed [OW-1:0]     px_c_r, py_c_r, px_d_r, py_d_r;
  logic                     last_r;

  // sequencer controls
  alu_op_t                  alu_op;
  logic signed [DEC_W-1:0]  alu_a, alu_b, alu_res;
  dst_t                     dst;
  logic                     x_inc, y_dec, set_r2, finish;
  logic                     emit_load, emit_drop;

  logic                     in_xfer;
  logic                     emit_ok;
  logic [MB_W-1:0]          xs;
  logic signed [MB_W-1:0]   yy;
  logic signed [OW-1:0]     cx_e, cy_e, xo, yo;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign emit_ok  = !out_valid_r || out_ready;

  // 2x+1 and y-1 for the region switch
  assign xs = {1'b0, x_r, 1'b1};
  assign yy = MB_W'(y_r) + {MB_W{1'b1}};

  mer_alu #(
    .COORD_BITS(COORD_BITS)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .res(alu_res)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_START) begin
            state_nxt = ST_LD_RX2;
          end else if (active_r) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_LD_RX2: state_nxt = ST_LD_RY2;
      ST_LD_RY2: state_nxt = ST_LD_T;
      ST_LD_T:   state_nxt = ST_LD_DY;
      ST_LD_DY:  state_nxt = ST_LD_D0;
      ST_LD_D0:  state_nxt = ST_LD_D1;
      ST_LD_D1:  state_nxt = ST_IDLE;
      ST_CHK: begin
        if (!r2_r && !(dx_r < dy_r)) begin
          state_nxt = ST_SW0;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SW0: state_nxt = ST_SW1;
      ST_SW1: state_nxt = ST_SW2;
      ST_SW2: state_nxt = ST_SW3;
      ST_SW3: state_nxt = ST_SW4;
      ST_SW4: state_nxt = ST_SW5;
      ST_SW5: state_nxt = ST_SW6;
      ST_SW6: state_nxt = ST_SW7;
      ST_SW7: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (r2_r && y_r < 0) begin
          state_nxt = ST_IDLE;
        end else if (emit_ok) begin
          state_nxt = ST_UP0;
        end
      end
      ST_UP0: state_nxt = ST_UP1;
      ST_UP1: state_nxt = ST_UP2;
      ST_UP2: state_nxt = br_r ? ST_IDLE : ST_UP3;
      ST_UP3: state_nxt = ST_UP4;
      ST_UP4: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: operand select, destination and side effects
  // --------------------------------------------------------------------------
  always_comb begin
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    dst       = DST_NONE;
    x_inc     = 1'b0;
    y_dec     = 1'b0;
    set_r2    = 1'b0;
    finish    = 1'b0;
    emit_load = 1'b0;
    emit_drop = 1'b0;
    case (state_r)
      ST_LD_RX2: begin
        alu_op = ALU_MUL;
        alu_a  = DEC_W'(rx_r);
        alu_b  = DEC_W'(rx_r);
        dst    = DST_RX2;
      end
      ST_LD_RY2: begin
        alu_op = ALU_MUL;
        alu_a  = DEC_W'(ry_r);
        alu_b  = DEC_W'(ry_r);
        dst    = DST_RY2;
      end
      ST_LD_T: begin
        alu_op = ALU_MUL;
        alu_a  = DEC_W'(rx2_r);
        alu_b  = DEC_W'(ry_r);
        dst    = DST_T;
      end
      ST_LD_DY: begin
        alu_a = t_r;
        alu_b = t_r;
        dst   = DST_DY;
      end
      ST_LD_D0: begin
        alu_a = DEC_W'(rx2_r);
        alu_b = DEC_W'(ry2_r) << 2;
        dst   = DST_DEC;
      end
      ST_LD_D1: begin
        alu_op = ALU_SUB;
        alu_a  = dec_r;
        alu_b  = t_r <<< 2;
        dst    = DST_DEC;
      end
      ST_SW0: begin
        alu_op = ALU_MUL;
        alu_a  = DEC_W'(ry2_r);
        alu_b  = DEC_W'(xs);
        dst    = DST_T;
      end
      ST_SW1: begin
        alu_op = ALU_MUL;
        alu_a  = t_r;
        alu_b  = DEC_W'(xs);
        dst    = DST_T;
      end
      ST_SW2: begin
        alu_op = ALU_MUL;
        alu_a  = DEC_W'(rx2_r);
        alu_b  = DEC_W'(yy);
        dst    = DST_U;
      end
      ST_SW3: begin
        alu_op = ALU_MUL;
        alu_a  = u_r;
        alu_b  = DEC_W'(yy);
        dst    = DST_U;
      end
      ST_SW4: begin
        alu_op = ALU_MUL;
        alu_a  = DEC_W'(rx2_r);
        alu_b  = DEC_W'(ry_r);
        dst    = DST_DEC;
      end
      ST_SW5: begin
        alu_op = ALU_MUL;
        alu_a  = dec_r;
        alu_b  = DEC_W'(ry_r);
        dst    = DST_DEC;
      end
      ST_SW6: begin
        alu_op = ALU_SUB;
        alu_a  = u_r;
        alu_b  = dec_r;
        dst    = DST_U;
      end
      ST_SW7: begin
        alu_a  = t_r;
        alu_b  = u_r <<< 2;
        dst    = DST_DEC;
        set_r2 = 1'b1;
      end
      ST_EMIT: begin
        if (r2_r && y_r < 0) begin
          emit_drop = 1'b1;
        end else if (emit_ok) begin
          emit_load = 1'b1;
        end
      end
      ST_UP0: begin
        if (!r2_r) begin
          alu_a = DEC_W'(dx_r);
          alu_b = DEC_W'(ry2_r) << 1;
          dst   = DST_DX;
        end else begin
          alu_op = ALU_SUB;
          alu_a  = DEC_W'(dy_r);
          alu_b  = DEC_W'(rx2_r) << 1;
          dst    = DST_DY;
        end
      end
      ST_UP1: begin
        if (br_r) begin
          alu_a = dec_r;
          alu_b = r2_r ? (DEC_W'(rx2_r) << 2) : (DEC_W'(ry2_r) << 2);
          dst   = DST_DEC;
        end else if (!r2_r) begin
          alu_op = ALU_SUB;
          alu_a  = DEC_W'(dy_r);
          alu_b  = DEC_W'(rx2_r) << 1;
          dst    = DST_DY;
          y_dec  = 1'b1;
        end else begin
          alu_a = DEC_W'(dx_r);
          alu_b = DEC_W'(ry2_r) << 1;
          dst   = DST_DX;
          x_inc = 1'b1;
        end
      end
      ST_UP2: begin
        alu_a = dec_r;
        dst   = DST_DEC;
        if (r2_r && br_r) begin
          alu_op = ALU_SUB;
          alu_b  = DEC_W'(dy_r) <<< 2;
        end else begin
          alu_b  = DEC_W'(dx_r) <<< 2;
        end
        finish = br_r;
      end
      ST_UP3: begin
        alu_op = ALU_SUB;
        alu_a  = dec_r;
        alu_b  = DEC_W'(dy_r) <<< 2;
        dst    = DST_DEC;
      end
      ST_UP4: begin
        alu_a  = dec_r;
        alu_b  = r2_r ? (DEC_W'(rx2_r) << 2) : (DEC_W'(ry2_r) << 2);
        dst    = DST_DEC;
        finish = 1'b1;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    active_nxt    = active_r;
    r2_nxt        = r2_r;
    br_nxt        = br_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dec_nxt       = dec_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // load a new ellipse and reset the walk
    if (in_xfer && in_opcode == OP_START) begin
      rx_nxt     = in_radius_x;
      ry_nxt     = in_radius_y;
      cx_nxt     = in_center_x;
      cy_nxt     = in_center_y;
      x_nxt      = '0;
      y_nxt      = YW'(in_radius_y);
      dx_nxt     = '0;
      r2_nxt     = 1'b0;
      active_nxt = 1'b1;
    end

    case (dst)
      DST_RX2: rx2_nxt = alu_res[R2W-1:0];
      DST_RY2: ry2_nxt = alu_res[R2W-1:0];
      DST_T:   t_nxt   = alu_res;
      DST_U:   u_nxt   = alu_res;
      DST_DX:  dx_nxt  = alu_res[DX_W-1:0];
      DST_DY:  dy_nxt  = alu_res[DX_W-1:0];
      DST_DEC: dec_nxt = alu_res;
      default: dec_nxt = dec_r;
    endcase

    if (set_r2) begin
      r2_nxt = 1'b1;
    end

    if (emit_drop) begin
      active_nxt = 1'b0;
    end

    if (emit_load) begin
      out_valid_nxt = 1'b1;
      br_nxt        = r2_r ? (dec_r > 0) : (dec_r < 0);
    end

    if (x_inc || (finish && !r2_r)) begin
      x_nxt = x_r + XW'(1);
    end
    if (y_dec || (finish && r2_r)) begin
      y_nxt = y_r - YW'(1);
    end
    // the walk ends once y drops below zero in region 2
    if (finish && r2_r && y_r == '0) begin
      active_nxt = 1'b0;
    end
  end

  // point group offsets around the center
  assign cx_e = OW'(cx_r);
  assign cy_e = OW'(cy_r);
  assign xo   = OW'(x_r);
  assign yo   = OW'(y_r);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      r2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      r2_r        <= r2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    br_r  <= br_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dec_r <= dec_nxt;
    t_r   <= t_nxt;
    u_r   <= u_nxt;
    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    rx2_r <= rx2_nxt;
    ry2_r <= ry2_nxt;
    if (emit_load) begin
      px_a_r <= cx_e + xo;
      py_a_r <= cy_e + yo;
      px_b_r <= cx_e - xo;
      py_b_r <= cy_e + yo;
      px_c_r <= cx_e + xo;
      py_c_r <= cy_e - yo;
      px_d_r <= cx_e - xo;
      py_d_r <= cy_e - yo;
      last_r <= r2_r && (y_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_px_a  = px_a_r;
  assign out_py_a  = py_a_r;
  assign out_px_b  = px_b_r;
  assign out_py_b  = py_b_r;
  assign out_px_c  = px_c_r;
  assign out_py_c  = py_c_r;
  assign out_px_d  = px_d_r;
  assign out_py_d  = py_d_r;
  assign out_last  = last_r;

endmodule

// File: rtl/core/mer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_alu
// Shared add / subtract / multiply unit for the rasterizer sequencer.
// ----------------------------------------------------------------------------
module mer_alu
  import mer_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  alu_op_t                                op,
  input  logic signed [4*(COORD_BITS-1)+7:0]     a,
  input  logic signed [4*(COORD_BITS-1)+7:0]     b,
  output logic signed [4*(COORD_BITS-1)+7:0]     res
);

  localparam int RAD_BITS = COORD_BITS - 1;
  localparam int DEC_W    = 4 * RAD_BITS + 8;
  localparam int DX_W     = 3 * RAD_BITS + 3;
  localparam int MB_W     = RAD_BITS + 3;
  localparam int PW       = DX_W + MB_W;

  logic signed [DX_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [PW-1:0]   prod;

  // multiplier sees the low bits of each operand only
  assign ma   = a[DX_W-1:0];
  assign mb   = b[MB_W-1:0];
  assign prod = ma * mb;

  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      ALU_MUL: res = {{(DEC_W-PW){prod[PW-1]}}, prod};
      default: res = a;
    endcase
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midpoint_ellipse_rasterizer_unit. Start and step
// transfers go through a valid/ready sender with random gaps. A walk model
// predicts every point group, and a receiver with random stalls compares each
// accepted group, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import mer_pkg::*;

  localparam int CB             = COORD_BITS_DEF;
  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 600_000;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct {
    logic signed [CB:0] px_a, py_a, px_b, py_b, px_c, py_c, px_d, py_d;
    logic               is_last;
  } point_group_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_opcode;
  logic [CB-2:0]        in_radius_x;
  logic [CB-2:0]        in_radius_y;
  logic signed [CB-1:0] in_center_x;
  logic signed [CB-1:0] in_center_y;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CB:0]   out_px_a, out_py_a, out_px_b, out_py_b;
  logic signed [CB:0]   out_px_c, out_py_c, out_px_d, out_py_d;
  logic                 out_last;

  // walk state of the model
  bit     walk_active;
  bit     walk_region2;
  longint walk_ox, walk_oy, walk_dx, walk_dy, walk_dec;
  longint walk_rx, walk_ry, walk_cx, walk_cy;

  point_group_t expected_groups[$];
  int           n_mismatches = 0;
  int           n_items      = 0;
  int           tx_calm      = 0;
  int           rx_calm      = 0;
  bit           tx_nogap     = 1'b0;
  bit           rx_hold_req  = 1'b0;
  bit           rx_holding   = 1'b0;

  midpoint_ellipse_rasterizer_unit #(
    .COORD_BITS(CB)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_radius_x(in_radius_x),
    .in_radius_y(in_radius_y),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_px_a   (out_px_a),
    .out_py_a   (out_py_a),
    .out_px_b   (out_px_b),
    .out_py_b   (out_py_b),
    .out_px_c   (out_px_c),
    .out_py_c   (out_py_c),
    .out_px_d   (out_px_d),
    .out_py_d   (out_py_d),
    .out_last   (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one accepted transfer to the walk; returns 1 unless it was an idle step.
  function automatic bit advance_ellipse(input logic op, input logic [CB-2:0] rx_i,
                                         input logic [CB-2:0] ry_i,
                                         input logic signed [CB-1:0] cx_i,
                                         input logic signed [CB-1:0] cy_i);
    longint       rx2, ry2, xs, yy;
    point_group_t g;
    if (op == OP_START) begin
      walk_rx      = longint'(rx_i);
      walk_ry      = longint'(ry_i);
      walk_cx      = longint'(cx_i);
      walk_cy      = longint'(cy_i);
      rx2          = walk_rx * walk_rx;
      ry2          = walk_ry * walk_ry;
      walk_ox      = 0;
      walk_oy      = walk_ry;
      walk_dx      = 0;
      walk_dy      = 2 * rx2 * walk_ry;
      walk_dec     = 4 * ry2 - 4 * rx2 * walk_ry + rx2;
      walk_region2 = 1'b0;
      walk_active  = 1'b1;
      return 1'b1;
    end
    if (!walk_active) return 1'b0;
    rx2 = walk_rx * walk_rx;
    ry2 = walk_ry * walk_ry;
    // switch to region 2 once the slope reaches one
    if (!walk_region2 && walk_dx >= walk_dy) begin
      xs           = 2 * walk_ox + 1;
      yy           = walk_oy - 1;
      walk_dec     = ry2 * xs * xs + 4 * rx2 * yy * yy - 4 * rx2 * ry2;
      walk_region2 = 1'b1;
    end
    if (walk_region2 && walk_oy < 0) begin
      walk_active = 1'b0;
      return 1'b1;
    end
    g.px_a    = (CB+1)'(walk_cx + walk_ox);
    g.py_a    = (CB+1)'(walk_cy + walk_oy);
    g.px_b    = (CB+1)'(walk_cx - walk_ox);
    g.py_b    = (CB+1)'(walk_cy + walk_oy);
    g.px_c    = (CB+1)'(walk_cx + walk_ox);
    g.py_c    = (CB+1)'(walk_cy - walk_oy);
    g.px_d    = (CB+1)'(walk_cx - walk_ox);
    g.py_d    = (CB+1)'(walk_cy - walk_oy);
    g.is_last = walk_region2 && (walk_oy == 0);
    expected_groups.push_back(g);
    if (!walk_region2) begin
      walk_dx += 2 * ry2;
      if (walk_dec < 0) begin
        walk_dec += 4 * (walk_dx + ry2);
      end else begin
        walk_oy  -= 1;
        walk_dy  -= 2 * rx2;
        walk_dec += 4 * (walk_dx - walk_dy + ry2);
      end
      walk_ox += 1;
    end else begin
      walk_dy -= 2 * rx2;
      if (walk_dec > 0) begin
        walk_dec += 4 * (rx2 - walk_dy);
      end else begin
        walk_ox  += 1;
        walk_dx  += 2 * ry2;
        walk_dec += 4 * (walk_dx - walk_dy + rx2);
      end
      walk_oy -= 1;
      if (walk_oy < 0) walk_active = 1'b0;
    end
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic op, input logic [CB-2:0] rx_i,
                           input logic [CB-2:0] ry_i, input logic signed [CB-1:0] cx_i,
                           input logic signed [CB-1:0] cy_i);
    int gap;
    if (tx_nogap) begin
      gap = 0;
    end else if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) tx_calm = $urandom_range(8, 40);
      gap = $urandom_range(0, 13);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode   <= op;
    in_radius_x <= rx_i;
    in_radius_y <= ry_i;
    in_center_x <= cx_i;
    in_center_y <= cy_i;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (advance_ellipse(op, rx_i, ry_i, cx_i, cy_i)) n_items++;
    @(negedge clk);
  endtask

  // Step payload fields are don't-care; fill them with noise.
  task automatic send_step();
    send_item(OP_STEP, (CB-1)'($urandom), (CB-1)'($urandom), CB'($urandom),
              CB'($urandom));
  endtask

  task automatic run_walk(input int max_steps);
    int k;
    k = 0;
    while (walk_active && k < max_steps) begin
      send_step();
      k++;
    end
  endtask

  // Hold the sender until every predicted group has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_groups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CB-2:0] pick_radius(input bit wide);
    int r;
    r = $urandom_range(0, 99);
    if (wide) begin
      if (r < 25) return {(CB-1){1'b1}};
      if (r < 35) return '0;
      return (CB-1)'($urandom);
    end
    if (r < 70) return (CB-1)'($urandom_range(0, 12));
    if (r < 95) return (CB-1)'($urandom_range(0, 40));
    return (CB-1)'($urandom_range(0, 150));
  endfunction

  function automatic logic signed [CB-1:0] pick_center();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return {1'b1, {(CB-1){1'b0}}};
    if (r == 1) return {1'b0, {(CB-1){1'b1}}};
    return CB'($urandom);
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatches++;
    end
  endtask

  task automatic test_idle_step();
    send_step();
    wait_drained();
  endtask

  task automatic test_zero_radii();
    send_item(OP_START, '0, '0, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}});
    send_step();
    send_step();
    send_item(OP_START, '0, 3, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}});
    run_walk(10);
    send_item(OP_START, 5, '0, 17, -9);
    run_walk(10);
    wait_drained();
  endtask

  task automatic test_extreme_radii();
    send_item(OP_START, {(CB-1){1'b1}}, {(CB-1){1'b1}},
              {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}});
    run_walk(3);
    send_item(OP_START, {(CB-1){1'b1}}, '0, {1'b1, {(CB-1){1'b0}}},
              {1'b0, {(CB-1){1'b1}}});
    run_walk(3);
    // restart in the middle of a walk, then finish a tiny ellipse
    send_item(OP_START, {(CB-1){1'b1}}, {(CB-1){1'b1}}, '0, '0);
    send_step();
    send_item(OP_START, 3, 2, -5, 6);
    run_walk(20);
    send_step();
    wait_drained();
  endtask

  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    wait (rx_holding);
    tx_nogap = 1'b1;
    send_item(OP_START, 20, 12, pick_center(), pick_center());
    run_walk(1000);
    tx_nogap = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_walks();
    int kind;
    int first;
    first = n_items;
    while (n_items - first < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        send_item(OP_START, pick_radius(1'b0), pick_radius(1'b0), pick_center(),
                  pick_center());
        run_walk(100_000);
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_step();
      end else if (kind < 88) begin
        send_item(OP_START, pick_radius(1'($urandom_range(0, 1))), pick_radius(1'b0),
                  pick_center(), pick_center());
        run_walk($urandom_range(0, 8));
      end else if (kind < 97) begin
        send_item(OP_START, pick_radius(1'b1), pick_radius(1'b1), pick_center(),
                  pick_center());
        run_walk($urandom_range(1, 40));
      end else begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  // receiver: random stalls, one long hold on request, check every transfer
  initial begin
    int           w;
    point_group_t g;
    out_ready <= 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_holding  = 1'b1;
        out_ready  <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_holding  = 1'b0;
      end else begin
        if (rx_calm > 0) begin
          rx_calm--;
          w = 0;
        end else begin
          if ($urandom_range(0, 24) == 0) rx_calm = $urandom_range(8, 40);
          w = $urandom_range(0, 13);
        end
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && !rx_hold_req) @(posedge clk);
      if (out_valid) begin
        if (expected_groups.size() == 0) begin
          $error("point group transfer with nothing expected");
          n_mismatches++;
        end else begin
          g = expected_groups.pop_front();
          compare_field("px_a", longint'(g.px_a), longint'(out_px_a));
          compare_field("py_a", longint'(g.py_a), longint'(out_py_a));
          compare_field("px_b", longint'(g.px_b), longint'(out_px_b));
          compare_field("py_b", longint'(g.py_b), longint'(out_py_b));
          compare_field("px_c", longint'(g.px_c), longint'(out_px_c));
          compare_field("py_c", longint'(g.py_c), longint'(out_py_c));
          compare_field("px_d", longint'(g.px_d), longint'(out_px_d));
          compare_field("py_d", longint'(g.py_d), longint'(out_py_d));
          compare_field("last", longint'(g.is_last), longint'(out_last));
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_START;
    in_radius_x <= '0;
    in_radius_y <= '0;
    in_center_x <= '0;
    in_center_y <= '0;
    walk_active = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_step();
    test_zero_radii();
    test_extreme_radii();
    test_output_stall();
    test_random_walks();
    if (expected_groups.size() != 0) begin
      $error("%0d point groups never arrived", expected_groups.size());
      n_mismatches++;
    end
    if (n_mismatches == 0) begin
      $display("midpoint_ellipse_rasterizer_unit test passed");
    end else begin
      $display("midpoint_ellipse_rasterizer_unit test failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("midpoint_ellipse_rasterizer_unit test failed");
    $finish;
  end

endmodule
